/* design/bplr_pkg.sv */
// Package for the button press / long press / auto-repeat detector.
// Holds state, mode and event codes, field widths and register reset values.
// No dependencies.
`default_nettype none

package bplr_pkg;

    localparam int NOW_W      = 32;
    localparam int LONG_W     = 16;
    localparam int SLOT_W     = 10;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int EVENT_W    = 2;

    // register indexes on the write port
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_PERIOD = 1'b1;

    localparam logic [LONG_W-1:0] LONG_PRESS_RESET    = 16'd1000;
    localparam logic [SLOT_W-1:0] REPEAT_PERIOD_RESET = 10'd200;

    localparam logic [SLOT_W:0] MS_PER_SECOND = 11'd1000;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DIVIDE,
        ST_FINISH
    } state_t;

    typedef enum logic [1:0] {
        MODE_FREE,
        MODE_WAIT_LONG,
        MODE_WAIT_REPEAT
    } mode_t;

    typedef enum logic [EVENT_W-1:0] {
        EV_NONE   = 2'd0,
        EV_PRESS  = 2'd1,
        EV_LONG   = 2'd2,
        EV_REPEAT = 2'd3
    } event_t;

endpackage

`default_nettype wire

/* design/bplr_in_if.sv */
// Input channel of the button detector: one tick with level and millisecond time.
// Depends on bplr_pkg.
`default_nettype none

interface bplr_in_if;
    logic                        valid;
    logic                        ready;
    logic                        level;
    logic [bplr_pkg::NOW_W-1:0]  now_ms;

    modport source (output valid, output level, output now_ms, input ready);
    modport sink   (input valid, input level, input now_ms, output ready);
endinterface

`default_nettype wire

/* design/bplr_out_if.sv */
// Output channel of the button detector: one event and the down level per tick.
// Depends on bplr_pkg.
`default_nettype none

interface bplr_out_if;
    logic                          valid;
    logic                          ready;
    logic [bplr_pkg::EVENT_W-1:0]  event_res;
    logic                          is_down;

    modport source (output valid, output event_res, output is_down, input ready);
    modport sink   (input valid, input event_res, input is_down, output ready);
endinterface

`default_nettype wire

/* design/button_press_longpress_repeat_core.sv */
// Button press, long press and auto-repeat detector. Each input transfer is one tick
// (debounced active-low level plus millisecond time) and yields exactly one output
// transfer carrying the event (none, press, long press, repeat) and the down level.
// A tick runs through its steps in order: the accept, a bit-serial scan that forms
// the held time compare (LSB first) and the time modulo 1000 (MSB first) in one pass,
// a restoring divide by the repeat period, and the commit of the result. A new tick
// is taken while the previous result still waits in the output register; the commit
// waits only if that register is still full.
// Depends on bplr_pkg, bplr_in_if and bplr_out_if.
`default_nettype none

module button_press_longpress_repeat_core #(
    parameter int TIME_BITS = 32
) (
    input  wire                                   clk,
    input  wire                                   rst_n,
    input  wire                                   cfg_we,
    input  wire [bplr_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  wire [bplr_pkg::CFG_DATA_W-1:0]        cfg_data,
    bplr_in_if.sink                               in_ch,
    bplr_out_if.source                            out_ch
);

    localparam int SLOT_W = bplr_pkg::SLOT_W;
    localparam int LONG_W = bplr_pkg::LONG_W;
    localparam int CNT_W  = $clog2(TIME_BITS);
    localparam logic [CNT_W-1:0] SCAN_LAST = CNT_W'(TIME_BITS - 1);
    localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(SLOT_W - 1);

    bplr_pkg::state_t state_reg, state_next;

    logic [LONG_W-1:0]    long_ms_reg;
    logic [SLOT_W-1:0]    period_reg;
    logic                 prev_level_reg;
    bplr_pkg::mode_t      mode_reg;
    logic [TIME_BITS-1:0] press_time_reg;
    logic [SLOT_W-1:0]    slot_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic                 out_valid_reg;

    logic                 lvl_reg;
    logic [TIME_BITS-1:0] now_lo_reg;
    logic [TIME_BITS-1:0] now_hi_reg;
    logic [LONG_W-1:0]    thr_reg;
    logic                 borrow_reg;
    logic                 ge_reg;
    logic [SLOT_W-1:0]    rem_reg;
    logic [SLOT_W-1:0]    quo_reg;
    bplr_pkg::event_t     out_event_reg;
    logic                 out_down_reg;

    logic in_ready;
    logic accept;
    logic scan_en;
    logic div_en;
    logic fin_en;
    logic cnt_zero;

    logic [TIME_BITS-1:0] now_ext;

    // serial subtract / compare
    logic sub_a;
    logic sub_b;
    logic sub_d;
    logic borrow_n;
    logic ge_n;

    // restoring modulo 1000
    logic [SLOT_W:0]   mod_try;
    logic [SLOT_W:0]   mod_diff;
    logic [SLOT_W-1:0] mod_n;

    // restoring divide by the repeat period
    logic [SLOT_W-1:0] divisor;
    logic [SLOT_W:0]   div_try;
    logic [SLOT_W:0]   div_diff;
    logic              div_ge;
    logic [SLOT_W-1:0] div_rem_n;

    // commit decision
    bplr_pkg::event_t fin_event;
    bplr_pkg::mode_t  fin_mode;
    logic             fin_slot_load;
    logic [SLOT_W-1:0] fin_slot;

    assign accept   = in_ch.valid && in_ready;
    assign cnt_zero = (cnt_reg == '0);
    assign now_ext  = TIME_BITS'(in_ch.now_ms);

    // ---------------- state machine ----------------

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bplr_pkg::ST_IDLE:
            begin
                if (accept)
                    state_next = bplr_pkg::ST_SCAN;
            end
            bplr_pkg::ST_SCAN:
            begin
                if (cnt_zero)
                    state_next = bplr_pkg::ST_DIVIDE;
            end
            bplr_pkg::ST_DIVIDE:
            begin
                if (cnt_zero)
                    state_next = bplr_pkg::ST_FINISH;
            end
            bplr_pkg::ST_FINISH:
            begin
                if (fin_en)
                    state_next = bplr_pkg::ST_IDLE;
            end
            default:
                state_next = bplr_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        scan_en  = 1'b0;
        div_en   = 1'b0;
        fin_en   = 1'b0;
        unique case (state_reg)
            bplr_pkg::ST_IDLE:   in_ready = 1'b1;
            bplr_pkg::ST_SCAN:   scan_en  = 1'b1;
            bplr_pkg::ST_DIVIDE: div_en   = 1'b1;
            bplr_pkg::ST_FINISH: fin_en   = !out_valid_reg || out_ch.ready;
            default:             in_ready = 1'b0;
        endcase
    end

    // ---------------- datapath ----------------

    // held = now - press_time, compared against the threshold one bit at a time
    assign sub_a    = now_lo_reg[0];
    assign sub_b    = press_time_reg[0];
    assign sub_d    = sub_a ^ sub_b ^ borrow_reg;
    assign borrow_n = (!sub_a && sub_b) || (!(sub_a ^ sub_b) && borrow_reg);
    // the highest differing bit decides, equal keeps held >= threshold
    assign ge_n     = (sub_d != thr_reg[0]) ? sub_d : ge_reg;

    assign mod_try  = {rem_reg, now_hi_reg[TIME_BITS-1]};
    assign mod_diff = mod_try - bplr_pkg::MS_PER_SECOND;
    assign mod_n    = (mod_try >= bplr_pkg::MS_PER_SECOND) ? mod_diff[SLOT_W-1:0]
                                                           : mod_try[SLOT_W-1:0];

    // a zero period counts as one
    assign divisor   = (period_reg == '0) ? SLOT_W'(1) : period_reg;
    assign div_try   = {rem_reg, quo_reg[SLOT_W-1]};
    assign div_diff  = div_try - {1'b0, divisor};
    assign div_ge    = (div_try >= {1'b0, divisor});
    assign div_rem_n = div_ge ? div_diff[SLOT_W-1:0] : div_try[SLOT_W-1:0];

    always_comb
    begin
        fin_event     = bplr_pkg::EV_NONE;
        fin_mode      = bplr_pkg::MODE_FREE;
        fin_slot_load = 1'b0;
        fin_slot      = quo_reg;
        priority if (!lvl_reg && prev_level_reg)
        begin
            fin_event = bplr_pkg::EV_PRESS;
            fin_mode  = bplr_pkg::MODE_WAIT_LONG;
        end
        else if (!lvl_reg && mode_reg == bplr_pkg::MODE_WAIT_LONG)
        begin
            if (ge_reg)
            begin
                fin_event     = bplr_pkg::EV_LONG;
                fin_mode      = bplr_pkg::MODE_WAIT_REPEAT;
                fin_slot_load = 1'b1;
                fin_slot      = '0;
            end
            else
            begin
                fin_mode = bplr_pkg::MODE_WAIT_LONG;
            end
        end
        else if (!lvl_reg && mode_reg == bplr_pkg::MODE_WAIT_REPEAT)
        begin
            fin_mode = bplr_pkg::MODE_WAIT_REPEAT;
            if (quo_reg != slot_reg)
            begin
                fin_event     = bplr_pkg::EV_REPEAT;
                fin_slot_load = 1'b1;
            end
        end
        else
        begin
            fin_mode = bplr_pkg::MODE_FREE;
        end
    end

    // ---------------- control registers ----------------

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= bplr_pkg::ST_IDLE;
            long_ms_reg    <= bplr_pkg::LONG_PRESS_RESET;
            period_reg     <= bplr_pkg::REPEAT_PERIOD_RESET;
            prev_level_reg <= 1'b1;
            mode_reg       <= bplr_pkg::MODE_FREE;
            press_time_reg <= '0;
            slot_reg       <= '0;
            cnt_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we)
            begin
                unique case (cfg_index)
                    bplr_pkg::CFG_LONG_PRESS:    long_ms_reg <= cfg_data;
                    bplr_pkg::CFG_REPEAT_PERIOD: period_reg  <= cfg_data[SLOT_W-1:0];
                    default:                     long_ms_reg <= long_ms_reg;
                endcase
            end

            if (accept)
            begin
                cnt_reg <= SCAN_LAST;
                // a press never needs the old press time, so it is loaded right away
                if (!in_ch.level && prev_level_reg)
                    press_time_reg <= now_ext;
            end
            else if (scan_en)
            begin
                // full rotation leaves press time intact at the end of the scan
                press_time_reg <= {press_time_reg[0], press_time_reg[TIME_BITS-1:1]};
                cnt_reg        <= cnt_zero ? DIV_LAST : cnt_reg - CNT_W'(1);
            end
            else if (div_en)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end

            if (fin_en)
            begin
                prev_level_reg <= lvl_reg;
                mode_reg       <= fin_mode;
                if (fin_slot_load)
                    slot_reg <= fin_slot;
            end

            if (fin_en)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // ---------------- payload registers ----------------

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            lvl_reg    <= in_ch.level;
            now_lo_reg <= now_ext;
            now_hi_reg <= now_ext;
            thr_reg    <= long_ms_reg;
            borrow_reg <= 1'b0;
            ge_reg     <= 1'b1;
            rem_reg    <= '0;
        end
        else if (scan_en)
        begin
            now_lo_reg <= {1'b0, now_lo_reg[TIME_BITS-1:1]};
            now_hi_reg <= {now_hi_reg[TIME_BITS-2:0], 1'b0};
            thr_reg    <= {1'b0, thr_reg[LONG_W-1:1]};
            borrow_reg <= borrow_n;
            ge_reg     <= ge_n;
            if (cnt_zero)
            begin
                quo_reg <= mod_n;
                rem_reg <= '0;
            end
            else
            begin
                rem_reg <= mod_n;
            end
        end
        else if (div_en)
        begin
            rem_reg <= div_rem_n;
            quo_reg <= {quo_reg[SLOT_W-2:0], div_ge};
        end

        if (fin_en)
        begin
            out_event_reg <= fin_event;
            out_down_reg  <= !lvl_reg;
        end
    end

    assign in_ch.ready      = in_ready;
    assign out_ch.valid     = out_valid_reg;
    assign out_ch.event_res = out_event_reg;
    assign out_ch.is_down   = out_down_reg;

    // ---------------- assertions ----------------

    // a result only appears out of the commit cycle
    a_out_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == bplr_pkg::ST_FINISH))
        else $error("output valid rose without a commit");

    // any held mode implies the last tick saw the button down
    a_mode_needs_down: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg != bplr_pkg::MODE_FREE) |-> !prev_level_reg)
        else $error("held mode while last level was released");

    // a pending long press result always leaves the machine waiting for repeats
    a_long_then_repeat: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_event_reg == bplr_pkg::EV_LONG)
            |-> (mode_reg == bplr_pkg::MODE_WAIT_REPEAT))
        else $error("long press reported but mode is not waiting for repeat");

    // the divide never runs past its ten quotient bits
    a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bplr_pkg::ST_DIVIDE) |-> (cnt_reg <= DIV_LAST))
        else $error("divide step counter out of range");

endmodule

`default_nettype wire
